@@ sv/ngh_pkg.sv @@
// ----------------------------------------------------------------------------
// ngh_pkg
// Shared constants and register codes for the note gate with hysteresis.
// ----------------------------------------------------------------------------
package ngh_pkg;

  // Sizing
  localparam int NOTE_COUNT_DEF = 128;
  localparam int NOTE_W         = 7;
  localparam int POWER_W        = 24;
  localparam int STATUS_W       = 8;
  localparam int CHAN_W         = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  // Octave spacing and widest handled span, in semitones
  localparam logic [NOTE_W:0] OCTAVE_STEP = 8'd12;
  localparam logic [NOTE_W:0] MAX_SPAN    = 8'd64;

  // Status byte high nibbles
  localparam logic [STATUS_W-1:0] STATUS_ON  = 8'h90;
  localparam logic [STATUS_W-1:0] STATUS_OFF = 8'h80;

  // Operation codes
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_NOTE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_NOTE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL  = 3'd5;

  // Register reset values
  localparam logic [POWER_W-1:0] RST_ON_THRESHOLD  = 24'd3840;
  localparam logic [POWER_W-1:0] RST_OFF_THRESHOLD = 24'd548;
  localparam logic               RST_HARMONIC_EN   = 1'b0;
  localparam logic [NOTE_W-1:0]  RST_LOWEST_NOTE   = 7'd30;
  localparam logic [NOTE_W:0]    RST_HIGHEST_NOTE  = 8'd74;
  localparam logic [CHAN_W-1:0]  RST_MIDI_CHANNEL  = 4'd2;

endpackage

@@ sv/ngh_if.sv @@
// ----------------------------------------------------------------------------
// ngh_in_if / ngh_out_if
// Valid/ready channels: power reports and flushes in, MIDI note events out.
// ----------------------------------------------------------------------------
interface ngh_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [ngh_pkg::NOTE_W-1:0]  note_number;
  logic [ngh_pkg::POWER_W-1:0] power_level;

  modport source (output valid, output operation, output note_number,
                  output power_level, input ready);
  modport sink   (input valid, input operation, input note_number,
                  input power_level, output ready);
endinterface

interface ngh_out_if;
  logic                         valid;
  logic                         ready;
  logic [ngh_pkg::STATUS_W-1:0] status_byte;
  logic [ngh_pkg::NOTE_W-1:0]   event_note;
  logic                         last;

  modport source (output valid, output status_byte, output event_note,
                  output last, input ready);
  modport sink   (input valid, input status_byte, input event_note,
                  input last, output ready);
endinterface

@@ sv/note_gate_with_hysteresis_top.sv @@
// ----------------------------------------------------------------------------
// note_gate_with_hysteresis_top
// Per-note on/off gate with hysteresis and octave suppression, MIDI events out.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  notes     in   operation, note_number, power_level
//  events    out  status_byte, event_note, last
//  cfg_*     in   cfg_write, cfg_index, cfg_data (write only)
//
//  Report: probes at most 5 lower octaves (only with suppression on), then
//  reads and writes back the note flag and emits up to two events; flush:
//  reads each note of the handled range. Both use the single flag read port.
//  Reset (rst, synchronous) clears all note flags at once through valid bits.
//  A full output register stalls the sequencer; input is taken only when idle.
// ----------------------------------------------------------------------------
module note_gate_with_hysteresis_top #(
  parameter int NOTE_COUNT = ngh_pkg::NOTE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ngh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ngh_pkg::CFG_DATA_W-1:0] cfg_data,
  ngh_in_if.sink                         notes,
  ngh_out_if.source                      events
);

  localparam int ADDR_W = $clog2(NOTE_COUNT);
  localparam int NW     = ngh_pkg::NOTE_W;
  localparam logic [NW:0] NOTE_LIMIT = NOTE_COUNT[NW:0];

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OCT  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_FCHK = 3'd4;
  localparam logic [2:0] S_FEND = 3'd5;

  // Configuration registers
  logic [ngh_pkg::POWER_W-1:0] on_thr;
  logic [ngh_pkg::POWER_W-1:0] off_thr;
  logic                        harm_en;
  logic [NW-1:0]               lowest;
  logic [NW:0]                 highest;
  logic [ngh_pkg::CHAN_W-1:0]  chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_thr  <= ngh_pkg::RST_ON_THRESHOLD;
      off_thr <= ngh_pkg::RST_OFF_THRESHOLD;
      harm_en <= ngh_pkg::RST_HARMONIC_EN;
      lowest  <= ngh_pkg::RST_LOWEST_NOTE;
      highest <= ngh_pkg::RST_HIGHEST_NOTE;
      chan    <= ngh_pkg::RST_MIDI_CHANNEL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ngh_pkg::CFG_ON_THRESHOLD:  on_thr  <= cfg_data;
        ngh_pkg::CFG_OFF_THRESHOLD: off_thr <= cfg_data;
        ngh_pkg::CFG_HARMONIC_EN:   harm_en <= cfg_data[0];
        ngh_pkg::CFG_LOWEST_NOTE:   lowest  <= cfg_data[NW-1:0];
        ngh_pkg::CFG_HIGHEST_NOTE:  highest <= cfg_data[NW:0];
        ngh_pkg::CFG_MIDI_CHANNEL:  chan    <= cfg_data[ngh_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handled range end: least of highest, lowest + span and note count
  logic [NW:0] low_ext;
  logic [NW:0] span_end;
  logic [NW:0] hi_a;
  logic [NW:0] hi;
  assign low_ext  = {1'b0, lowest};
  assign span_end = low_ext + ngh_pkg::MAX_SPAN;
  assign hi_a     = (highest > span_end) ? span_end : highest;
  assign hi       = (hi_a > NOTE_LIMIT) ? NOTE_LIMIT : hi_a;

  // Note flag memory, one read and one write port; valid bits give reset/flush
  logic               flag_mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] vld;
  logic               rd_en;
  logic [NW-1:0]      rd_note;
  logic               mem_q;
  logic               vld_q;
  logic               wr_en;
  logic               wr_data;
  logic               clear_all;
  logic               act;
  logic [NW-1:0]      note_q, note_q_next;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= flag_mem[rd_note[ADDR_W-1:0]];
      vld_q <= vld[rd_note[ADDR_W-1:0]];
    end
    if (wr_en) begin
      flag_mem[note_q[ADDR_W-1:0]] <= wr_data;
    end
  end

  assign act = mem_q & vld_q;

  // Sequencer registers
  logic [2:0]                  state, state_next;
  logic [NW-1:0]               ptr, ptr_next;
  logic [ngh_pkg::POWER_W-1:0] power_q, power_q_next;
  logic                        supp, supp_next;
  logic                        ev_on, ev_on_next;
  logic                        ev_off, ev_off_next;
  logic [NW-1:0]               pend_note, pend_note_next;
  logic                        pend_valid, pend_valid_next;
  logic                        out_valid, out_valid_next;
  logic [ngh_pkg::STATUS_W-1:0] out_status, out_status_next;
  logic [NW-1:0]               out_note, out_note_next;
  logic                        out_last, out_last_next;

  logic                        slot_free;
  logic                        accept;
  logic [NW:0]                 ptr_ext;
  logic [NW:0]                 oct_floor;
  logic [ngh_pkg::POWER_W-1:0] eff_power;
  logic                        turn_on;
  logic                        still_on;
  logic                        turn_off;
  logic [ngh_pkg::STATUS_W-1:0] st_on;
  logic [ngh_pkg::STATUS_W-1:0] st_off;

  assign slot_free = !out_valid || events.ready;
  assign accept    = notes.valid && notes.ready;
  assign ptr_ext   = {1'b0, ptr};
  assign oct_floor = low_ext + ngh_pkg::OCTAVE_STEP;
  assign eff_power = supp ? '0 : power_q;
  assign turn_on   = !act && (eff_power > on_thr);
  assign still_on  = act || turn_on;
  assign turn_off  = still_on && (eff_power < off_thr);
  assign st_on     = ngh_pkg::STATUS_ON | {{(ngh_pkg::STATUS_W-ngh_pkg::CHAN_W){1'b0}}, chan};
  assign st_off    = ngh_pkg::STATUS_OFF | {{(ngh_pkg::STATUS_W-ngh_pkg::CHAN_W){1'b0}}, chan};

  // Next-state and datapath control
  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    note_q_next     = note_q;
    power_q_next    = power_q;
    supp_next       = supp;
    ev_on_next      = ev_on;
    ev_off_next     = ev_off;
    pend_note_next  = pend_note;
    pend_valid_next = pend_valid;
    out_valid_next  = out_valid && !events.ready;
    out_status_next = out_status;
    out_note_next   = out_note;
    out_last_next   = out_last;
    rd_en           = 1'b0;
    rd_note         = note_q;
    wr_en           = 1'b0;
    wr_data         = 1'b0;
    clear_all       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          note_q_next  = notes.note_number;
          power_q_next = notes.power_level;
          supp_next    = 1'b0;
          if (notes.operation == ngh_pkg::OP_FLUSH) begin
            pend_valid_next = 1'b0;
            if (low_ext < hi) begin
              ptr_next   = lowest;
              rd_en      = 1'b1;
              rd_note    = lowest;
              state_next = S_FCHK;
            end else begin
              state_next = S_FEND;
            end
          end else if ((notes.note_number >= lowest) &&
                       ({1'b0, notes.note_number} < hi)) begin
            rd_en = 1'b1;
            if (harm_en && ({1'b0, notes.note_number} > oct_floor)) begin
              ptr_next   = notes.note_number - ngh_pkg::OCTAVE_STEP[NW-1:0];
              rd_note    = notes.note_number - ngh_pkg::OCTAVE_STEP[NW-1:0];
              state_next = S_OCT;
            end else begin
              rd_note    = notes.note_number;
              state_next = S_READ;
            end
          end
        end
      end

      // Probe one lower octave per cycle; stop at the first active one
      S_OCT: begin
        rd_en = 1'b1;
        if (act) begin
          supp_next  = 1'b1;
          rd_note    = note_q;
          state_next = S_READ;
        end else if (ptr_ext > oct_floor) begin
          ptr_next   = ptr - ngh_pkg::OCTAVE_STEP[NW-1:0];
          rd_note    = ptr - ngh_pkg::OCTAVE_STEP[NW-1:0];
        end else begin
          rd_note    = note_q;
          state_next = S_READ;
        end
      end

      // Apply hysteresis and write the flag back before the next read
      S_READ: begin
        wr_en       = 1'b1;
        wr_data     = still_on && !turn_off;
        ev_on_next  = turn_on;
        ev_off_next = turn_off;
        state_next  = (turn_on || turn_off) ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_note_next  = note_q;
          if (ev_on) begin
            out_status_next = st_on;
            out_last_next   = !ev_off;
            ev_on_next      = 1'b0;
            if (!ev_off) state_next = S_IDLE;
          end else begin
            out_status_next = st_off;
            out_last_next   = 1'b1;
            ev_off_next     = 1'b0;
            state_next      = S_IDLE;
          end
        end
      end

      // Scan the range; hold one found note back so the final one can carry last
      S_FCHK: begin
        if (!(act && pend_valid && !slot_free)) begin
          if (act) begin
            if (pend_valid) begin
              out_valid_next  = 1'b1;
              out_status_next = st_off;
              out_note_next   = pend_note;
              out_last_next   = 1'b0;
            end
            pend_note_next  = ptr;
            pend_valid_next = 1'b1;
          end
          if ((ptr_ext + 8'd1) < hi) begin
            ptr_next = ptr + 7'd1;
            rd_en    = 1'b1;
            rd_note  = ptr + 7'd1;
          end else begin
            state_next = S_FEND;
          end
        end
      end

      S_FEND: begin
        if (!pend_valid) begin
          clear_all  = 1'b1;
          state_next = S_IDLE;
        end else if (slot_free) begin
          out_valid_next  = 1'b1;
          out_status_next = st_off;
          out_note_next   = pend_note;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          clear_all       = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      supp       <= 1'b0;
      ev_on      <= 1'b0;
      ev_off     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      vld        <= '0;
    end else begin
      state      <= state_next;
      supp       <= supp_next;
      ev_on      <= ev_on_next;
      ev_off     <= ev_off_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (clear_all) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[note_q[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    note_q     <= note_q_next;
    power_q    <= power_q_next;
    pend_note  <= pend_note_next;
    out_status <= out_status_next;
    out_note   <= out_note_next;
    out_last   <= out_last_next;
  end

  assign notes.ready        = (state == S_IDLE);
  assign events.valid       = out_valid;
  assign events.status_byte = out_status;
  assign events.event_note  = out_note;
  assign events.last        = out_last;

  // Checks
  a_emit_has_event: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (ev_on || ev_off))
    else $error("emit state with no pending event");

  a_oct_above_low: assert property (@(posedge clk) disable iff (rst)
    (state == S_OCT) |-> (ptr_ext > low_ext))
    else $error("octave probe at or below lowest note");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCHK) |-> (ptr_ext < hi))
    else $error("flush scan beyond range end");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FEND && !pend_valid) |=> (vld == '0))
    else $error("flags not cleared after flush");

endmodule

@@ tb/tb_note_gate_with_hysteresis_top.sv @@
// ----------------------------------------------------------------------------
// tb_note_gate_with_hysteresis_top
// Drives power reports and flushes into the note gate, predicts the MIDI note
// events from a shadow copy of the note flags and registers, and checks every
// event beat in order. Both channels idle at random; registers change between
// phases, once the gate has drained.
// ----------------------------------------------------------------------------
module tb_note_gate_with_hysteresis_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NOTES         = ngh_pkg::NOTE_COUNT_DEF;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic                        op;
    logic [ngh_pkg::NOTE_W-1:0]  note;
    logic [ngh_pkg::POWER_W-1:0] power;
  } note_beat_t;

  typedef struct {
    logic [ngh_pkg::STATUS_W-1:0] status;
    logic [ngh_pkg::NOTE_W-1:0]   note;
    logic                         tail;
  } midi_event_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [ngh_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ngh_pkg::CFG_DATA_W-1:0] cfg_data;

  ngh_in_if  note_ch ();
  ngh_out_if event_ch ();

  note_gate_with_hysteresis_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .notes     (note_ch.sink),
    .events    (event_ch.source)
  );

  // Shadow registers and note flags
  logic [ngh_pkg::POWER_W-1:0] gate_on_level;
  logic [ngh_pkg::POWER_W-1:0] gate_off_level;
  bit                          suppress_en;
  int                          low_note;
  int                          high_bound;
  logic [ngh_pkg::CHAN_W-1:0]  channel;
  bit                          note_flags [NOTES];

  note_beat_t  pending_beats [$];
  midi_event_t expected_events [$];
  note_beat_t  cur_beat;
  int          queued_total;
  int          accepted_total = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  bit          steady;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Upper end (exclusive) of the handled note range
  function automatic int gate_bound();
    int b;
    b = high_bound;
    if (b > low_note + int'(ngh_pkg::MAX_SPAN)) b = low_note + int'(ngh_pkg::MAX_SPAN);
    if (b > NOTES) b = NOTES;
    return b;
  endfunction

  // True when a flag 12, 24, ... semitones lower, above the lowest note, is set
  function automatic bit octave_shadowed(int n);
    int j;
    j = n - int'(ngh_pkg::OCTAVE_STEP);
    while (j > low_note) begin
      if (j < NOTES && note_flags[j]) return 1'b1;
      j -= int'(ngh_pkg::OCTAVE_STEP);
    end
    return 1'b0;
  endfunction

  function automatic void push_event(logic [ngh_pkg::STATUS_W-1:0] base, int n,
                                     bit tail);
    midi_event_t ev;
    ev.status = base | {{(ngh_pkg::STATUS_W-ngh_pkg::CHAN_W){1'b0}}, channel};
    ev.note   = n[ngh_pkg::NOTE_W-1:0];
    ev.tail   = tail;
    expected_events.push_back(ev);
  endfunction

  // Update the flags for one accepted beat and queue the events it causes
  function automatic void predict_events(note_beat_t b);
    int                          bound;
    int                          n;
    int                          last_hit;
    logic [ngh_pkg::POWER_W-1:0] pwr;
    bit                          fire_on;
    bit                          fire_off;
    bound = gate_bound();
    if (b.op == ngh_pkg::OP_FLUSH) begin
      last_hit = -1;
      for (n = low_note; n < bound; n++)
        if (note_flags[n]) last_hit = n;
      for (n = low_note; n < bound; n++)
        if (note_flags[n]) push_event(ngh_pkg::STATUS_OFF, n, n == last_hit);
      for (n = 0; n < NOTES; n++) note_flags[n] = 1'b0;
    end else begin
      n = int'(b.note);
      if (n < low_note || n >= bound) return;
      pwr = b.power;
      if (suppress_en && octave_shadowed(n)) pwr = '0;
      fire_on = !note_flags[n] && pwr > gate_on_level;
      if (fire_on) note_flags[n] = 1'b1;
      fire_off = note_flags[n] && pwr < gate_off_level;
      if (fire_off) note_flags[n] = 1'b0;
      if (fire_on) push_event(ngh_pkg::STATUS_ON, n, !fire_off);
      if (fire_off) push_event(ngh_pkg::STATUS_OFF, n, 1'b1);
    end
  endfunction

  function automatic bit idle_roll();
    if (steady) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  // Input driver: hold a beat until taken, then predict it
  always @(posedge clk) begin
    if (rst) begin
      note_ch.valid <= 1'b0;
    end else begin
      if (note_ch.valid && note_ch.ready) begin
        predict_events(cur_beat);
        accepted_total++;
      end
      if (!note_ch.valid || note_ch.ready) begin
        if (pending_beats.size() != 0 && !idle_roll()) begin
          cur_beat = pending_beats.pop_front();
          note_ch.valid       <= 1'b1;
          note_ch.operation   <= cur_beat.op;
          note_ch.note_number <= cur_beat.note;
          note_ch.power_level <= cur_beat.power;
        end else begin
          note_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_error(string what, midi_event_t want, midi_event_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("%s: expected status %h note %0d last %0b, got status %h note %0d last %0b",
               what, want.status, want.note, want.tail, got.status, got.note, got.tail);
  endtask

  // Event monitor: compare each taken beat with the oldest prediction
  always @(posedge clk) begin
    midi_event_t got;
    midi_event_t want;
    if (rst) begin
      event_ch.ready <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        got.status = event_ch.status_byte;
        got.note   = event_ch.event_note;
        got.tail   = event_ch.last;
        if (expected_events.size() == 0) begin
          want = '{default: '0};
          flag_error("no event expected", want, got);
        end else begin
          want = expected_events.pop_front();
          if (got.status !== want.status || got.note !== want.note ||
              got.tail !== want.tail)
            flag_error("event mismatch", want, got);
        end
      end
      event_ch.ready <= !idle_roll();
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_note_gate_with_hysteresis_top: errors");
      $finish;
    end
  end

  task automatic put_reg(logic [ngh_pkg::CFG_IDX_W-1:0] idx,
                         logic [ngh_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ngh_pkg::CFG_ON_THRESHOLD:  gate_on_level  = val[ngh_pkg::POWER_W-1:0];
      ngh_pkg::CFG_OFF_THRESHOLD: gate_off_level = val[ngh_pkg::POWER_W-1:0];
      ngh_pkg::CFG_HARMONIC_EN:   suppress_en    = val[0];
      ngh_pkg::CFG_LOWEST_NOTE:   low_note       = int'(val[ngh_pkg::NOTE_W-1:0]);
      ngh_pkg::CFG_HIGHEST_NOTE:  high_bound     = int'(val[ngh_pkg::NOTE_W:0]);
      ngh_pkg::CFG_MIDI_CHANNEL:  channel        = val[ngh_pkg::CHAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(logic [ngh_pkg::POWER_W-1:0] on_v,
                             logic [ngh_pkg::POWER_W-1:0] off_v,
                             bit harm, int lo, int hi, int chan);
    put_reg(ngh_pkg::CFG_ON_THRESHOLD, on_v);
    put_reg(ngh_pkg::CFG_OFF_THRESHOLD, off_v);
    put_reg(ngh_pkg::CFG_HARMONIC_EN, ngh_pkg::CFG_DATA_W'(harm));
    put_reg(ngh_pkg::CFG_LOWEST_NOTE, ngh_pkg::CFG_DATA_W'(lo));
    put_reg(ngh_pkg::CFG_HIGHEST_NOTE, ngh_pkg::CFG_DATA_W'(hi));
    put_reg(ngh_pkg::CFG_MIDI_CHANNEL, ngh_pkg::CFG_DATA_W'(chan));
    cfg_write <= 1'b0;
  endtask

  function automatic void add_report(int n, logic [ngh_pkg::POWER_W-1:0] pwr);
    note_beat_t b;
    b.op    = ngh_pkg::OP_REPORT;
    b.note  = n[ngh_pkg::NOTE_W-1:0];
    b.power = pwr;
    pending_beats.push_back(b);
    queued_total++;
  endfunction

  // Flush with random filler in the unused fields
  function automatic void add_flush();
    note_beat_t b;
    b.op    = ngh_pkg::OP_FLUSH;
    b.note  = ngh_pkg::NOTE_W'($urandom_range(127));
    b.power = ngh_pkg::POWER_W'($urandom());
    pending_beats.push_back(b);
    queued_total++;
  endfunction

  // Mostly notes in range, many of them an octave apart
  function automatic int pick_note();
    int bound;
    int span;
    int r;
    int n;
    bound = gate_bound();
    span  = bound - low_note;
    r     = $urandom_range(99);
    if (span <= 0 || r < 12) return $urandom_range(127);
    if (r < 50) begin
      n = low_note + $urandom_range(3) + int'(ngh_pkg::OCTAVE_STEP) * $urandom_range(5);
      if (n < bound) return n;
    end
    return low_note + $urandom_range(span - 1);
  endfunction

  // Powers at and around both thresholds, plus the extremes
  function automatic logic [ngh_pkg::POWER_W-1:0] pick_power();
    logic [ngh_pkg::POWER_W-1:0] lo;
    logic [ngh_pkg::POWER_W-1:0] hi;
    lo = (gate_on_level < gate_off_level) ? gate_on_level : gate_off_level;
    hi = (gate_on_level < gate_off_level) ? gate_off_level : gate_on_level;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return gate_on_level - 1'b1;
      3: return gate_on_level;
      4: return gate_on_level + 1'b1;
      5: return gate_off_level - 1'b1;
      6: return gate_off_level;
      7: return gate_off_level + 1'b1;
      8: return ngh_pkg::POWER_W'($urandom_range(hi, lo));
      default: return ngh_pkg::POWER_W'($urandom());
    endcase
  endfunction

  function automatic void run_random(int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 5) add_flush();
      else add_report(pick_note(), pick_power());
    end
  endfunction

  // Hold until every queued beat is taken and every event has come out
  task automatic wait_drained();
    while (accepted_total != queued_total || expected_events.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                          k;
    int                          lo_i;
    int                          hi_i;
    logic [ngh_pkg::POWER_W-1:0] on_v;
    logic [ngh_pkg::POWER_W-1:0] off_v;

    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    steady              = 1'b0;
    queued_total        = 0;
    gate_on_level       = ngh_pkg::RST_ON_THRESHOLD;
    gate_off_level      = ngh_pkg::RST_OFF_THRESHOLD;
    suppress_en         = ngh_pkg::RST_HARMONIC_EN;
    low_note            = int'(ngh_pkg::RST_LOWEST_NOTE);
    high_bound          = int'(ngh_pkg::RST_HIGHEST_NOTE);
    channel             = ngh_pkg::RST_MIDI_CHANNEL;
    for (k = 0; k < NOTES; k++) note_flags[k] = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: range edges, thresholds exactly met, flush twice
    add_report(29, '1);
    add_report(74, '1);
    add_report(127, '1);
    add_report(0, '0);
    add_report(30, 24'd3841);
    add_report(30, 24'd3840);
    add_report(30, 24'd548);
    add_report(30, 24'd547);
    add_report(73, 24'd3840);
    add_report(73, 24'd3841);
    add_report(31, '1);
    add_report(45, '0);
    add_flush();
    add_flush();
    run_random(30);
    settle();

    // Octave suppression, wide range capped at 64 notes, top channel
    load_config(24'd1000, 24'd200, 1'b1, 20, 100, 15);
    add_report(45, 24'd5000);
    add_report(33, 24'd5000);
    add_report(45, '1);
    add_report(57, '1);
    add_report(20, 24'd5000);
    add_report(32, 24'd5000);
    add_report(83, 24'd5000);
    add_report(84, 24'd5000);
    add_flush();
    run_random(40);
    // pause the sender until the gate has emptied
    wait_drained();
    run_random(40);
    settle();

    // Off above on: one report gives both events; no idling in this stretch
    steady = 1'b1;
    load_config('0, '1, 1'b0, 0, 128, 0);
    add_report(0, 24'd5);
    add_report(63, '1);
    add_report(64, '1);
    add_report(0, '0);
    run_random(60);
    settle();
    steady = 1'b0;

    // Nothing can turn on; only the top note is handled
    load_config('1, '0, 1'b0, 127, 128, 6);
    run_random(15);
    settle();

    // Empty range: reports ignored, flush clears flags left from before
    load_config(24'd100, 24'd50, 1'b1, 100, 50, 3);
    add_report(100, '1);
    add_report(49, '1);
    add_flush();
    run_random(10);
    settle();

    load_config(24'd300, 24'd100, 1'b1, 64, 128, 9);
    run_random(80);
    settle();

    // Random settings, the first with thresholds over the full span
    for (k = 0; k < 3; k++) begin
      on_v  = (k == 0) ? ngh_pkg::POWER_W'($urandom()) :
                         ngh_pkg::POWER_W'($urandom_range(20000));
      off_v = (k == 0) ? ngh_pkg::POWER_W'($urandom()) :
                         ngh_pkg::POWER_W'($urandom_range(20000));
      lo_i  = $urandom_range(120);
      hi_i  = lo_i + $urandom_range(70, 1);
      if (hi_i > 128) hi_i = 128;
      load_config(on_v, off_v, 1'($urandom_range(1)), lo_i, hi_i, $urandom_range(15));
      run_random(45);
      settle();
    end

    if (error_count == 0) begin
      $display("tb_note_gate_with_hysteresis_top: clean");
    end else begin
      $display("tb_note_gate_with_hysteresis_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ngh_pkg.sv
sv/ngh_if.sv
sv/note_gate_with_hysteresis_top.sv
tb/tb_note_gate_with_hysteresis_top.sv
